@@ sv/wfs_pkg.sv @@
// shared constants, types and helpers for the damped 2-D wave stencil block
// no dependencies; used by every module of the block
package wfs_pkg;

	// geometry and number format
	localparam int VALUE_BITS     = 20;
	localparam int MAX_COLS       = 256;
	localparam int MAX_ROWS       = 1024;
	localparam int MIN_DIM        = 3;
	localparam int COL_BITS       = $clog2(MAX_COLS);
	localparam int ROW_BITS       = $clog2(MAX_ROWS);
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_HALF      = 1 << (COEF_FRAC_BITS - 1);

	// configuration register widths
	localparam int COLS_CFG_BITS  = 9;
	localparam int ROWS_CFG_BITS  = 11;
	localparam int C2_BITS        = 15;
	localparam int DAMP_BITS      = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;

	// configuration reset values
	localparam logic [COLS_CFG_BITS-1:0] GRID_COLS_RST = COLS_CFG_BITS'(80);
	localparam logic [ROWS_CFG_BITS-1:0] GRID_ROWS_RST = ROWS_CFG_BITS'(24);
	localparam logic [C2_BITS-1:0]       SPEED_SQ_RST  = C2_BITS'(13271);
	localparam logic [DAMP_BITS-1:0]     DAMPING_RST   = DAMP_BITS'(65077);

	// display thresholds on |value| in Q.14
	localparam int BLANK_MAX = 2621;
	localparam int LVL_T1    = 18351;
	localparam int LVL_T2    = 34079;
	localparam int LVL_T3    = 49808;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_GRID_COLS = 2'd0,
		CFG_GRID_ROWS = 2'd1,
		CFG_SPEED_SQ  = 2'd2,
		CFG_DAMPING   = 2'd3
	} cfg_reg_t;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [COL_BITS-1:0]          col_t;
	typedef logic [ROW_BITS-1:0]          row_t;
	typedef logic [3:0]                   level_t;

	localparam level_t LVL_BLANK       = 4'd0;
	localparam level_t LVL_TROUGH_BASE = 4'd1;
	localparam level_t LVL_CREST_BASE  = 4'd5;
	localparam level_t LVL_MAX         = 4'd8;

	// one incoming cell
	typedef struct packed {
		value_t cur_value;
		value_t prev_value;
	} wfs_in_t;

	// one result
	typedef struct packed {
		value_t new_value;
		level_t display_level;
		col_t   cell_col;
		row_t   cell_row;
		logic   frame_last;
	} wfs_out_t;

	// per-cell bookkeeping that travels down the pipeline
	typedef struct packed {
		col_t col;
		row_t row;
		logic has_above;
		logic has_own;
		logic interior;
		logic last;
	} wfs_tag_t;

	// finished update handed from the datapath to the output stage
	typedef struct packed {
		logic     valid;
		wfs_tag_t tag;
		value_t   value;
		level_t   level;
	} wfs_calc_t;

	// display level from a saturated value
	function automatic level_t level_of(value_t v);
		logic [VALUE_BITS:0] a;
		logic [1:0]          lv;
		level_t              base;
		a = v[VALUE_BITS-1] ? ({1'b0, ~v} + (VALUE_BITS+1)'(1)) : {1'b0, v};
		if (a >= LVL_T3) lv = 2'd3;
		else if (a >= LVL_T2) lv = 2'd2;
		else if (a >= LVL_T1) lv = 2'd1;
		else lv = 2'd0;
		base = v[VALUE_BITS-1] ? LVL_TROUGH_BASE : LVL_CREST_BASE;
		if (a <= BLANK_MAX) level_of = LVL_BLANK;
		else level_of = base + {2'b00, lv};
	endfunction

endpackage

@@ sv/wave_fdtd_stencil_step.sv @@
// top level of the streaming damped 2-D wave equation step
// depends on wfs_pkg, wfs_line_store and wfs_update
//
// Cells enter in raster order, one item per clock while cell_ready is high,
// and the block counts column and row itself. The result for the cell at
// row r-1, column c leaves when the cell at row r, column c has entered, so
// row 0 yields nothing on entry and each cell of the last row yields two
// results (the cell above, then itself, a zero border). In steady state the
// block takes one cell per clock unless res_ready holds the output; on the
// last row the single output register stalls the pipeline for the two
// results of each cell. The line-store read and the output are registered,
// with the arithmetic stages between them. The line stores are not cleared
// at reset; a full first row must pass before any stored value is used.
// Configuration writes are always taken; the coefficients are read part way
// down the pipeline, so write only while no item is in flight.
module wave_fdtd_stencil_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cell_valid,
	output logic                                cell_ready,
	input  wfs_pkg::wfs_in_t                    cell_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output wfs_pkg::wfs_out_t                   res_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [wfs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CB = wfs_pkg::COL_BITS;
	localparam int RB = wfs_pkg::ROW_BITS;

	logic [wfs_pkg::COLS_CFG_BITS-1:0] grid_cols_q;
	logic [wfs_pkg::ROWS_CFG_BITS-1:0] grid_rows_q;
	logic [wfs_pkg::C2_BITS-1:0]       speed_sq_q;
	logic [wfs_pkg::DAMP_BITS-1:0]     damping_q;

	logic [CB:0]       cols_eff;
	logic [RB:0]       rows_eff;
	wfs_pkg::col_t     col_q;
	wfs_pkg::row_t     row_q;
	logic              wrap_pre;
	wfs_pkg::col_t     c_acc, c_acc_nxt, col_nxt;
	wfs_pkg::row_t     r_acc, row_nxt;
	logic [RB:0]       r_tmp, r_inc;
	logic [CB:0]       c_inc;
	logic              row_end;
	wfs_pkg::wfs_tag_t tag_acc;

	logic              adv, accept;
	logic              vld_s1;
	wfs_pkg::wfs_in_t  cell_s1;
	wfs_pkg::wfs_tag_t tag_s1;

	logic              wr_en;
	wfs_pkg::value_t   mem_u, mem_e, mem_n, mem_p;
	wfs_pkg::wfs_calc_t calc;

	logic              pend_a, pend_b, out_free, out_load, done_a_q, out_valid_q;
	wfs_pkg::wfs_out_t out_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= wfs_pkg::GRID_COLS_RST;
			grid_rows_q <= wfs_pkg::GRID_ROWS_RST;
			speed_sq_q  <= wfs_pkg::SPEED_SQ_RST;
			damping_q   <= wfs_pkg::DAMPING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (wfs_pkg::cfg_reg_t'(cfg_index))
				wfs_pkg::CFG_GRID_COLS: grid_cols_q <= cfg_data[wfs_pkg::COLS_CFG_BITS-1:0];
				wfs_pkg::CFG_GRID_ROWS: grid_rows_q <= cfg_data[wfs_pkg::ROWS_CFG_BITS-1:0];
				wfs_pkg::CFG_SPEED_SQ:  speed_sq_q  <= cfg_data[wfs_pkg::C2_BITS-1:0];
				wfs_pkg::CFG_DAMPING:   damping_q   <= cfg_data[wfs_pkg::DAMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamp geometry
	always_comb begin
		if (grid_cols_q < wfs_pkg::MIN_DIM) cols_eff = (CB+1)'(wfs_pkg::MIN_DIM);
		else if (grid_cols_q > wfs_pkg::MAX_COLS) cols_eff = (CB+1)'(wfs_pkg::MAX_COLS);
		else cols_eff = (CB+1)'(grid_cols_q);
		if (grid_rows_q < wfs_pkg::MIN_DIM) rows_eff = (RB+1)'(wfs_pkg::MIN_DIM);
		else if (grid_rows_q > wfs_pkg::MAX_ROWS) rows_eff = (RB+1)'(wfs_pkg::MAX_ROWS);
		else rows_eff = (RB+1)'(grid_rows_q);
	end

	// position of the arriving cell and the one after it
	always_comb begin
		wrap_pre  = {1'b0, col_q} >= cols_eff;
		c_acc     = wrap_pre ? '0 : col_q;
		r_tmp     = {1'b0, row_q} + (RB+1)'(wrap_pre);
		r_acc     = (r_tmp >= rows_eff) ? '0 : r_tmp[RB-1:0];
		c_acc_nxt = c_acc + wfs_pkg::col_t'(1);
		c_inc     = {1'b0, c_acc} + (CB+1)'(1);
		r_inc     = {1'b0, r_acc} + (RB+1)'(1);
		row_end   = c_inc >= cols_eff;
		col_nxt   = row_end ? '0 : c_inc[CB-1:0];
		if (!row_end) row_nxt = r_acc;
		else if (r_inc >= rows_eff) row_nxt = '0;
		else row_nxt = r_inc[RB-1:0];
		tag_acc.col       = c_acc;
		tag_acc.row       = r_acc;
		tag_acc.has_above = r_acc != '0;
		tag_acc.has_own   = r_inc == rows_eff;
		tag_acc.interior  = (r_acc >= RB'(2)) && (c_acc != '0)
			&& (({1'b0, c_acc} + (CB+1)'(2)) <= cols_eff);
		tag_acc.last      = c_inc == cols_eff;
	end

	// handshake and stall
	assign pend_a   = calc.valid && calc.tag.has_above && !done_a_q;
	assign pend_b   = calc.valid && calc.tag.has_own;
	assign out_free = !out_valid_q || res_ready;
	assign out_load = (pend_a || pend_b) && out_free;
	assign adv      = !(pend_a || pend_b) || (out_load && !(pend_a && pend_b));
	assign accept   = cell_valid && adv;
	assign cell_ready = adv;
	assign wr_en    = adv && vld_s1;

	// counters and first stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (adv) vld_s1 <= cell_valid;
			if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	// first stage payload, aligned with the line-store read data
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_data;
			tag_s1  <= tag_acc;
		end
	end

	wfs_line_store u_line_store (
		.clk    (clk),
		.rd_en  (accept),
		.rd_col (c_acc),
		.wr_en  (wr_en),
		.wr_col (tag_s1.col),
		.wr_cur (cell_s1.cur_value),
		.wr_prv (cell_s1.prev_value),
		.wr_two (mem_u),
		.u      (mem_u),
		.e      (mem_e),
		.n      (mem_n),
		.p      (mem_p)
	);

	wfs_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_s1 (vld_s1),
		.tag_s1 (tag_s1),
		.cur    (cell_s1.cur_value),
		.u      (mem_u),
		.n      (mem_n),
		.e      (mem_e),
		.p      (mem_p),
		.c2     (speed_sq_q),
		.damp   (damping_q),
		.calc   (calc)
	);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_a_q    <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
			if (adv) done_a_q <= 1'b0;
			else if (out_load && pend_a) done_a_q <= 1'b1;
		end
	end

	// result above first, then the last-row cell itself
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (pend_a) begin
				out_q.new_value     <= calc.value;
				out_q.display_level <= calc.level;
				out_q.cell_col      <= calc.tag.col;
				out_q.cell_row      <= calc.tag.row - wfs_pkg::row_t'(1);
				out_q.frame_last    <= 1'b0;
			end else begin
				out_q.new_value     <= '0;
				out_q.display_level <= wfs_pkg::LVL_BLANK;
				out_q.cell_col      <= calc.tag.col;
				out_q.cell_row      <= calc.tag.row;
				out_q.frame_last    <= calc.tag.last;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// a new read never hits the column being written back
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && accept) |-> (tag_s1.col != c_acc) && (tag_s1.col != c_acc_nxt))
		else $error("line store read collides with write back");

	// the above result is never dropped when the pipeline moves on
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_a && adv) |-> out_load)
		else $error("pending result lost on advance");

	// the half-done flag only marks an item with two results
	assert property (@(posedge clk) disable iff (!arst_n)
		done_a_q |-> (calc.valid && calc.tag.has_above && calc.tag.has_own))
		else $error("half-done flag on an item with one result");

	// the final cell of the grid is a border
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.frame_last) |->
		(res_data.new_value == '0) && (res_data.display_level == wfs_pkg::LVL_BLANK))
		else $error("frame end item is not a zero border");

	// display level stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.display_level <= wfs_pkg::LVL_MAX))
		else $error("display level out of range");

endmodule

@@ sv/wfs_line_store.sv @@
// line stores: two rows of current values and one row of previous values
// depends on wfs_pkg; registered reads, one write address per cycle
module wfs_line_store (
	input  logic            clk,
	input  logic            rd_en,
	input  wfs_pkg::col_t   rd_col,
	input  logic            wr_en,
	input  wfs_pkg::col_t   wr_col,
	input  wfs_pkg::value_t wr_cur,
	input  wfs_pkg::value_t wr_prv,
	input  wfs_pkg::value_t wr_two,
	output wfs_pkg::value_t u,
	output wfs_pkg::value_t e,
	output wfs_pkg::value_t n,
	output wfs_pkg::value_t p
);

	wfs_pkg::value_t cur_above_mem [wfs_pkg::MAX_COLS];
	wfs_pkg::value_t two_above_mem [wfs_pkg::MAX_COLS];
	wfs_pkg::value_t prev_above_mem [wfs_pkg::MAX_COLS];
	wfs_pkg::col_t   rd_col_nxt;

	// east neighbour sits one column on
	assign rd_col_nxt = rd_col + wfs_pkg::col_t'(1);

	// row above moves down to two above as the new row is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cur_above_mem[wr_col]  <= wr_cur;
			two_above_mem[wr_col]  <= wr_two;
			prev_above_mem[wr_col] <= wr_prv;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			u <= cur_above_mem[rd_col];
			e <= cur_above_mem[rd_col_nxt];
			n <= two_above_mem[rd_col];
			p <= prev_above_mem[rd_col];
		end
	end

endmodule

@@ sv/wfs_update.sv @@
// stencil arithmetic: laplacian, speed product, rounding, damping, saturation
// depends on wfs_pkg; four pipeline stages that advance together on adv
module wfs_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             vld_s1,
	input  wfs_pkg::wfs_tag_t                tag_s1,
	input  wfs_pkg::value_t                  cur,
	input  wfs_pkg::value_t                  u,
	input  wfs_pkg::value_t                  n,
	input  wfs_pkg::value_t                  e,
	input  wfs_pkg::value_t                  p,
	input  logic [wfs_pkg::C2_BITS-1:0]      c2,
	input  logic [wfs_pkg::DAMP_BITS-1:0]    damp,
	output wfs_pkg::wfs_calc_t               calc
);

	localparam int LAP_BITS  = wfs_pkg::VALUE_BITS + 4;
	localparam int D_BITS    = wfs_pkg::VALUE_BITS + 2;
	localparam int PROD_BITS = LAP_BITS + wfs_pkg::C2_BITS + 1;
	localparam int S_BITS    = PROD_BITS + 1;
	localparam int T_BITS    = S_BITS - wfs_pkg::COEF_FRAC_BITS;
	localparam int M_BITS    = T_BITS + wfs_pkg::DAMP_BITS + 1;
	localparam int R_BITS    = M_BITS - wfs_pkg::COEF_FRAC_BITS;

	typedef logic signed [LAP_BITS-1:0]  lap_t;
	typedef logic signed [D_BITS-1:0]    d_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [S_BITS-1:0]    s_t;
	typedef logic signed [T_BITS-1:0]    t_t;
	typedef logic signed [M_BITS-1:0]    m_t;
	typedef logic signed [R_BITS-1:0]    r_t;

	localparam wfs_pkg::value_t VAL_MAX = {1'b0, {(wfs_pkg::VALUE_BITS-1){1'b1}}};
	localparam wfs_pkg::value_t VAL_MIN = {1'b1, {(wfs_pkg::VALUE_BITS-1){1'b0}}};

	wfs_pkg::value_t   w_q;
	logic              vld_s2, vld_s3, vld_s4, vld_s5;
	wfs_pkg::wfs_tag_t tag_s2, tag_s3, tag_s4, tag_s5;
	lap_t              lap_s2;
	d_t                d_s2, d_s3;
	prod_t             prod_s3;
	t_t                t_s4;
	m_t                m_s5;
	logic signed [wfs_pkg::C2_BITS:0]   c2_sx;
	logic signed [wfs_pkg::DAMP_BITS:0] damp_sx;
	s_t                s_sum;
	m_t                m_rnd;
	r_t                v_rnd;
	wfs_pkg::value_t   v_sat;

	assign c2_sx   = $signed({1'b0, c2});
	assign damp_sx = $signed({1'b0, damp});

	// valid and tag shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// rounded sum of centre term and speed term
	always_comb begin
		s_sum = (s_t'(d_s3) <<< wfs_pkg::COEF_FRAC_BITS) + s_t'(prod_s3)
			+ s_t'(wfs_pkg::COEF_HALF);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			// west neighbour is the previous cell's centre
			if (vld_s1) w_q <= u;
			lap_s2  <= lap_t'(n) + lap_t'(cur) + lap_t'(e) + lap_t'(w_q) - (lap_t'(u) <<< 2);
			d_s2    <= d_t'(u) + d_t'(u) - d_t'(p);
			prod_s3 <= lap_s2 * c2_sx;
			d_s3    <= d_s2;
			t_s4    <= $signed(s_sum[S_BITS-1:wfs_pkg::COEF_FRAC_BITS]);
			m_s5    <= t_s4 * damp_sx;
		end
	end

	// final rounding and saturation, borders give zero
	always_comb begin
		m_rnd = m_s5 + m_t'(wfs_pkg::COEF_HALF);
		v_rnd = $signed(m_rnd[M_BITS-1:wfs_pkg::COEF_FRAC_BITS]);
		if (v_rnd > r_t'(VAL_MAX)) v_sat = VAL_MAX;
		else if (v_rnd < r_t'(VAL_MIN)) v_sat = VAL_MIN;
		else v_sat = wfs_pkg::value_t'(v_rnd);
		if (!tag_s5.interior) v_sat = '0;
	end

	assign calc.valid = vld_s5;
	assign calc.tag   = tag_s5;
	assign calc.value = v_sat;
	assign calc.level = wfs_pkg::level_of(v_sat);

endmodule
